// ----- rtl/pidsl_pkg.sv -----
// Package for the PID step block: payload types, register codes, states and saturation helpers.
`default_nettype none
package pidsl_pkg;

	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// Angle fold bounds, 180 and 360 degrees in Q16.16
	localparam logic signed [32:0] ANGLE_HALF = 33'sd11796480;
	localparam logic signed [32:0] ANGLE_FULL = 33'sd23592960;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] sensed;
		logic               clear_state;
	} pid_in_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               integral_clamped;
		logic               drive_clamped;
	} pid_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_STEP_TIME,
		CFG_STEP_RATE,
		CFG_INT_LIMIT,
		CFG_OUT_LIMIT,
		CFG_WRAP_ANGLE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_DELTA,
		S_INT,
		S_ICLAMP,
		S_P1,
		S_P2,
		S_D1,
		S_D2,
		S_I1,
		S_I2,
		S_SUM,
		S_OUT
	} pid_state_t;

	// Saturate a 65-bit signed value to the signed 48-bit range
	function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
		logic in_range;
		in_range = (&v[64:47]) || !(|v[64:47]);
		if (in_range)
			return v[47:0];
		else if (v[64])
			return {1'b1, 47'b0};
		else
			return {1'b0, {47{1'b1}}};
	endfunction

	// Saturate a 50-bit signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic in_range;
		in_range = (&v[49:31]) || !(|v[49:31]);
		if (in_range)
			return v[31:0];
		else if (v[49])
			return {1'b1, 31'b0};
		else
			return {1'b0, {31{1'b1}}};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pid_step_with_limits_top.sv -----
// PID step with integral and output clamps, one shared 48x16 multiplier under a sequencer.
//
// Usage: one input word (target, sensed, clear_state) yields one output word
// (drive, integral_clamped, drive_clamped). Both channels use valid/ready;
// a word moves at a rising edge with valid and ready high.
// Gains, step time/rate, limits and the angle fold are set through the write
// port (cfg_wr_en, cfg_index, cfg_data) while no sample is in flight.
// in_ready is high only while the sequencer is idle, so the next sample is
// taken only after the last one has left the sequencer; a clear_state word
// goes from S_ERR straight to S_OUT.
// The sequence is set by the single multiplier: S_ERR forms the error,
// then eight back-to-back passes (integral step, derivative, and two 48x16
// passes for each gain term), S_I2 and S_SUM finish the last term and the
// sum, and S_OUT loads the output register.
// The output register lets the next sample enter while a result waits; a
// stalled receiver holds the sequencer in its last state until the word
// is taken.
// Reset clears the stored error and integral, loads the default register
// values and drops out_valid.
`default_nettype none
module pid_step_with_limits_top
	import pidsl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pid_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pid_out_t                  out_data,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [15:0] step_time_q, step_rate_q;
	logic [30:0] ilim_q, olim_q;
	logic        wrap_q;

	// Sequencer and datapath state
	pid_state_t         state_q, state_d;
	logic signed [31:0] tgt_q, sns_q;
	logic               clr_q;
	logic signed [31:0] err_q, prev_q;
	logic signed [32:0] delta_q;
	logic signed [47:0] integ_q, der_q;
	logic signed [63:0] prod_q;
	logic signed [64:0] tacc_q;
	logic signed [49:0] sum_q;
	logic               iflag_q;
	logic               out_valid_q;
	pid_out_t           out_data_q;

	// Control and combinational datapath signals
	logic               in_accept;
	logic               out_load;
	logic signed [47:0] mul_a;
	logic [15:0]        mul_b;
	logic signed [63:0] mul_p;
	logic signed [32:0] diff, folded;
	logic signed [31:0] err_next;
	logic signed [48:0] integ_sum;
	logic signed [47:0] integ_sat, lim48;
	logic signed [49:0] olim50;
	logic signed [47:0] term;
	pid_out_t           res;

	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= 32'd65536;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			step_time_q <= 16'd131;
			step_rate_q <= 16'd500;
			ilim_q      <= '0;
			olim_q      <= '0;
			wrap_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GAIN_P:     gain_p_q    <= cfg_data;
				CFG_GAIN_I:     gain_i_q    <= cfg_data;
				CFG_GAIN_D:     gain_d_q    <= cfg_data;
				CFG_STEP_TIME:  step_time_q <= cfg_data[15:0];
				CFG_STEP_RATE:  step_rate_q <= cfg_data[15:0];
				CFG_INT_LIMIT:  ilim_q      <= cfg_data[30:0];
				CFG_OUT_LIMIT:  olim_q      <= cfg_data[30:0];
				CFG_WRAP_ANGLE: wrap_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_ERR;
			S_ERR:    state_d = clr_q ? S_OUT : S_DELTA;
			S_DELTA:  state_d = S_INT;
			S_INT:    state_d = S_ICLAMP;
			S_ICLAMP: state_d = S_P1;
			S_P1:     state_d = S_P2;
			S_P2:     state_d = S_D1;
			S_D1:     state_d = S_D2;
			S_D2:     state_d = S_I1;
			S_I1:     state_d = S_I2;
			S_I2:     state_d = S_SUM;
			S_SUM:    state_d = S_OUT;
			S_OUT:    if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operand select
	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_DELTA: begin
				mul_a = {{16{err_q[31]}}, err_q};
				mul_b = step_time_q;
			end
			S_INT: begin
				mul_a = {{15{delta_q[32]}}, delta_q};
				mul_b = step_rate_q;
			end
			S_ICLAMP: begin
				mul_a = {{16{err_q[31]}}, err_q};
				mul_b = gain_p_q[15:0];
			end
			S_P1: begin
				mul_a = {{16{err_q[31]}}, err_q};
				mul_b = gain_p_q[31:16];
			end
			S_P2: begin
				mul_a = der_q;
				mul_b = gain_d_q[15:0];
			end
			S_D1: begin
				mul_a = der_q;
				mul_b = gain_d_q[31:16];
			end
			S_D2: begin
				mul_a = integ_q;
				mul_b = gain_i_q[15:0];
			end
			S_I1: begin
				mul_a = integ_q;
				mul_b = gain_i_q[31:16];
			end
			default: ;
		endcase
	end

	// Shared multiplier: signed 48 bits by unsigned 16 bits, full 64-bit product
	assign mul_p = $signed({{16{mul_a[47]}}, mul_a}) * $signed({1'b0, mul_b});

	// Form the error, fold it once by a full turn when enabled and it lies outside -180..180, saturate
	always_comb begin
		diff = {tgt_q[31], tgt_q} - {sns_q[31], sns_q};
		folded = diff;
		if (wrap_q && (diff > ANGLE_HALF))
			folded = diff - ANGLE_FULL;
		else if (wrap_q && (diff < -ANGLE_HALF))
			folded = diff + ANGLE_FULL;
		err_next = sat32({{17{folded[32]}}, folded});
	end

	// Integral step and limit
	assign integ_sum = {integ_q[47], integ_q} + {prod_q[63], prod_q[63:16]};
	assign integ_sat = sat48({{16{integ_sum[48]}}, integ_sum});
	assign lim48     = $signed({17'b0, ilim_q});

	// Saturated term from the accumulator
	assign term = sat48(tacc_q);

	// Output clamp
	assign olim50 = $signed({19'b0, olim_q});
	always_comb begin
		res.integral_clamped = iflag_q;
		res.drive_clamped    = 1'b0;
		res.drive            = sat32(sum_q);
		if (olim_q != '0) begin
			if (sum_q > olim50) begin
				res.drive         = $signed({1'b0, olim_q});
				res.drive_clamped = 1'b1;
			end else if (sum_q < -olim50) begin
				res.drive         = -$signed({1'b0, olim_q});
				res.drive_clamped = 1'b1;
			end
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_accept) begin
			tgt_q <= in_data.target;
			sns_q <= in_data.sensed;
			clr_q <= in_data.clear_state;
		end
		case (state_q)
			S_ERR: begin
				err_q <= err_next;
				if (clr_q)
					sum_q <= '0;
			end
			S_DELTA:  delta_q <= {err_q[31], err_q} - {prev_q[31], prev_q};
			S_ICLAMP: der_q <= sat48({prod_q[63], prod_q});
			S_P1:     tacc_q <= {prod_q[63], prod_q >>> FRAC_W};
			S_P2:     tacc_q <= tacc_q + {prod_q[63], prod_q};
			S_D1: begin
				tacc_q <= {prod_q[63], prod_q >>> FRAC_W};
				sum_q  <= {{2{term[47]}}, term};
			end
			S_D2:     tacc_q <= tacc_q + {prod_q[63], prod_q};
			S_I1: begin
				tacc_q <= {prod_q[63], prod_q >>> FRAC_W};
				sum_q  <= sum_q + {{2{term[47]}}, term};
			end
			S_I2:     tacc_q <= tacc_q + {prod_q[63], prod_q};
			S_SUM:    sum_q <= sum_q + {{2{term[47]}}, term};
			default: ;
		endcase
		if (out_load)
			out_data_q <= res;
	end

	// Controller state: previous error, integral and its clamp flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
			iflag_q <= 1'b0;
		end else begin
			case (state_q)
				S_ERR: begin
					if (clr_q) begin
						prev_q  <= '0;
						integ_q <= '0;
						iflag_q <= 1'b0;
					end
				end
				S_DELTA: prev_q <= err_q;
				S_INT:   integ_q <= integ_sat;
				S_ICLAMP: begin
					if ((ilim_q != '0) && (integ_q > lim48)) begin
						integ_q <= lim48;
						iflag_q <= 1'b1;
					end else if ((ilim_q != '0) && (integ_q < -lim48)) begin
						integ_q <= -lim48;
						iflag_q <= 1'b1;
					end else begin
						iflag_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Clear path zeroes the stored state and the sum before the output stage
	a_clear_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR && clr_q) |=>
			(state_q == S_OUT && sum_q == '0 && integ_q == '0 && prev_q == '0))
		else $error("clear word left state or sum nonzero");

	// Integral stays within its limit after the clamp step
	a_int_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ICLAMP && ilim_q != '0) |=>
			(integ_q <= $past(lim48) && integ_q >= -$past(lim48)))
		else $error("integral outside its limit after clamp");

	// No integral flag without an integral limit
	a_int_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ICLAMP && ilim_q == '0) |=> !iflag_q)
		else $error("integral flag set with limit disabled");

	// No output flag without an output limit
	a_out_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && olim_q == '0) |=> (out_valid_q && !out_data_q.drive_clamped))
		else $error("output flag set with limit disabled");

endmodule
`default_nettype wire

// ----- tb/tb_pid_step_with_limits_top.sv -----
// Testbench for the PID step block: queued stimulus, shadow predictor and scoreboard.
`timescale 1ns / 100ps
module tb_pid_step_with_limits_top;
	import pidsl_pkg::*;

	localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -S48_MAX - 1;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint FOLD_HALF = 64'sd11796480;
	localparam longint FOLD_FULL = 64'sd23592960;
	localparam logic [31:0] DEG180 = 32'd11796480;
	localparam int RUN_PHASES = 8;
	localparam int PHASE_WORDS = 200;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	pid_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pid_out_t    out_data;
	logic        cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the control registers, at reset values
	logic [31:0] kp_reg     = 32'h0001_0000;
	logic [31:0] ki_reg     = 32'h0;
	logic [31:0] kd_reg     = 32'h0;
	logic [15:0] period_reg = 16'd131;
	logic [15:0] rate_reg   = 16'd500;
	logic [30:0] ilim_reg   = 31'h0;
	logic [30:0] olim_reg   = 31'h0;
	logic        wrap_reg   = 1'b0;

	// Shadow copy of the loop state
	longint prev_err = 0;
	longint integ    = 0;

	pid_in_t  sample_q[$];
	pid_out_t drive_due_q[$];
	int  n_queued    = 0;
	int  n_checked   = 0;
	int  err_count   = 0;
	int  tx_gap_left = 0;
	int  rx_gap_left = 0;
	int  rx_hold_left = 0;
	bit  idle_en     = 1'b1;
	bit  hold_req    = 1'b0;

	pid_step_with_limits_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, 12 ns period, low phase first
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hold reset from the start, then release it for good
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Bound the run
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Floor of a * g / 2^16, with a held to 48 bits and g an unsigned Q16.16 gain
	function automatic longint gain_mul(input longint a, input logic [31:0] g);
		longint x, g_hi, g_lo;
		x = clip(a, S48_MIN, S48_MAX);
		g_hi = g[31:16];
		g_lo = g[15:0];
		return clip(x * g_hi + ((x * g_lo) >>> 16), S48_MIN, S48_MAX);
	endfunction

	// Advance the shadow loop state by one word and return the drive it yields
	function automatic pid_out_t next_drive(input pid_in_t w);
		longint err, pt, dt, it, acc, lim, rate_l, period_l;
		pid_out_t r;
		r = '0;
		if (w.clear_state) begin
			prev_err = 0;
			integ = 0;
			return r;
		end
		rate_l = rate_reg;
		period_l = period_reg;
		err = longint'(w.target) - longint'(w.sensed);
		if (wrap_reg) begin
			if (err > FOLD_HALF)
				err -= FOLD_FULL;
			else if (err < -FOLD_HALF)
				err += FOLD_FULL;
		end
		err = clip(err, S32_MIN, S32_MAX);
		pt = gain_mul(err, kp_reg);
		dt = gain_mul(clip((err - prev_err) * rate_l, S48_MIN, S48_MAX), kd_reg);
		integ = clip(integ + ((err * period_l) >>> 16), S48_MIN, S48_MAX);
		if (ilim_reg != 0) begin
			lim = ilim_reg;
			if (integ > lim) begin
				integ = lim;
				r.integral_clamped = 1'b1;
			end else if (integ < -lim) begin
				integ = -lim;
				r.integral_clamped = 1'b1;
			end
		end
		it = gain_mul(integ, ki_reg);
		acc = pt + dt + it;
		if (olim_reg != 0) begin
			lim = olim_reg;
			if (acc > lim) begin
				acc = lim;
				r.drive_clamped = 1'b1;
			end else if (acc < -lim) begin
				acc = -lim;
				r.drive_clamped = 1'b1;
			end
		end
		acc = clip(acc, S32_MIN, S32_MAX);
		prev_err = err;
		r.drive = acc[31:0];
		return r;
	endfunction

	function automatic pid_in_t sample(input logic [31:0] t, input logic [31:0] s,
			input logic c);
		pid_in_t w;
		w.target = t;
		w.sensed = s;
		w.clear_state = c;
		return w;
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return 32'h1;
		endcase
	endfunction

	// Mostly small or angle-edge errors so the integral and clamps get exercised
	function automatic pid_in_t random_sample();
		logic [31:0] s, t;
		s = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: t = s + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			4, 5: begin
				t = ($urandom_range(0, 1) ? s + DEG180 : s - DEG180);
				t = t + $urandom_range(0, 8) - 32'd4;
			end
			6: t = $urandom;
			7: begin
				s = edge_value();
				t = edge_value();
			end
			default: t = s + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
		endcase
		return sample(t, s, $urandom_range(0, 24) == 0);
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom_range(1, 32'h0100_0000);
			default: return $urandom_range(0, 32'h7FFF_FFFF);
		endcase
	endfunction

	task automatic push_sample(input pid_in_t w);
		sample_q.push_back(w);
		n_queued++;
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_GAIN_P:     kp_reg = val;
			CFG_GAIN_I:     ki_reg = val;
			CFG_GAIN_D:     kd_reg = val;
			CFG_STEP_TIME:  period_reg = val[15:0];
			CFG_STEP_RATE:  rate_reg = val[15:0];
			CFG_INT_LIMIT:  ilim_reg = val[30:0];
			CFG_OUT_LIMIT:  olim_reg = val[30:0];
			CFG_WRAP_ANGLE: wrap_reg = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every queued word has come back, then let the sequencer settle
	task automatic wait_idle();
		while (n_checked < n_queued)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Feed words from the queue, predicting each one as it is taken
	always @(posedge clk) begin : feed_proc
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				drive_due_q.push_back(next_drive(in_data));
			if (!in_valid || in_ready) begin
				offer = 1'b0;
				if (tx_gap_left > 0) begin
					tx_gap_left--;
				end else if (sample_q.size() != 0) begin
					offer = 1'b1;
					in_data <= sample_q.pop_front();
					if (idle_en && $urandom_range(0, 3) == 0)
						tx_gap_left = $urandom_range(1, 9);
				end
				in_valid <= offer;
			end
		end
	end

	// Check each output word against the oldest prediction and drive ready
	always @(posedge clk) begin : drain_proc
		pid_out_t want;
		logic take;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_due_q.size() == 0) begin
					note_error($sformatf("unexpected word drive=%0d", out_data.drive));
				end else begin
					want = drive_due_q.pop_front();
					n_checked++;
					if (out_data.drive !== want.drive)
						note_error($sformatf("drive: expected %0d, got %0d",
							want.drive, out_data.drive));
					if (out_data.integral_clamped !== want.integral_clamped)
						note_error($sformatf("integral_clamped: expected %0b, got %0b",
							want.integral_clamped, out_data.integral_clamped));
					if (out_data.drive_clamped !== want.drive_clamped)
						note_error($sformatf("drive_clamped: expected %0b, got %0b",
							want.drive_clamped, out_data.drive_clamped));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold_left = 300;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				take = 1'b0;
			end else if (rx_gap_left > 0) begin
				rx_gap_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				if (idle_en && $urandom_range(0, 4) == 0)
					rx_gap_left = $urandom_range(1, 9);
			end
			out_ready <= take;
		end
	end

	// Stimulus: directed words at reset settings, then a tuned setting, then random phases
	initial begin : stim_proc
		int ph;
		int k;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Extremes at reset register values
		push_sample(sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		push_sample(sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		push_sample(sample(32'h0, 32'h0, 1'b0));
		push_sample(sample(32'h0001_0000, 32'h0, 1'b0));
		push_sample(sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		push_sample(sample(32'hFFFF_FFFF, 32'h0, 1'b1));
		wait_idle();

		// Moderate gains, tight limits, angle fold on
		write_reg(CFG_GAIN_P, 32'h0002_0000);
		write_reg(CFG_GAIN_I, 32'h0000_8000);
		write_reg(CFG_GAIN_D, 32'h0000_0290);
		write_reg(CFG_STEP_TIME, 32'd655);
		write_reg(CFG_STEP_RATE, 32'd100);
		write_reg(CFG_INT_LIMIT, 32'h0003_0000);
		write_reg(CFG_OUT_LIMIT, 32'h0032_0000);
		write_reg(CFG_WRAP_ANGLE, 32'd1);

		// Fold edges: exactly half a turn stays, one step past it folds
		push_sample(sample(DEG180, 32'h0, 1'b0));
		push_sample(sample(DEG180 + 32'd1, 32'h0, 1'b0));
		push_sample(sample(32'h0, DEG180, 1'b0));
		push_sample(sample(32'h0, DEG180 + 32'd1, 1'b0));
		push_sample(sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		push_sample(sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		push_sample(sample(32'h0001_0000, 32'h0, 1'b0));
		// Steady error drives the integral into its clamp
		for (k = 0; k < 5; k++)
			push_sample(sample(32'h0064_0000, 32'h0, 1'b0));
		push_sample(sample(32'h0000_3039, 32'hFFFF_FC19, 1'b1));
		for (k = 0; k < 4; k++)
			push_sample(sample(32'hFF9C_0000, 32'h0, 1'b0));
		wait_idle();

		for (ph = 0; ph < RUN_PHASES; ph++) begin
			write_reg(CFG_GAIN_P, pick_gain());
			write_reg(CFG_GAIN_I, pick_gain());
			write_reg(CFG_GAIN_D, pick_gain());
			write_reg(CFG_STEP_TIME, $urandom_range(1, 16'hFFFF));
			write_reg(CFG_STEP_RATE, $urandom_range(1, 16'hFFFF));
			write_reg(CFG_INT_LIMIT, pick_limit());
			write_reg(CFG_OUT_LIMIT, pick_limit());
			write_reg(CFG_WRAP_ANGLE, $urandom_range(0, 1));
			case (ph)
				1: begin
					// Gains, period and rate at their top, limits off: saturation on every path
					write_reg(CFG_GAIN_P, 32'hFFFF_FFFF);
					write_reg(CFG_GAIN_I, 32'hFFFF_FFFF);
					write_reg(CFG_GAIN_D, 32'hFFFF_FFFF);
					write_reg(CFG_STEP_TIME, 32'hFFFF);
					write_reg(CFG_STEP_RATE, 32'hFFFF);
					write_reg(CFG_INT_LIMIT, 32'h0);
					write_reg(CFG_OUT_LIMIT, 32'h0);
				end
				2: begin
					// Zero period and rate freeze the integral and kill the derivative
					write_reg(CFG_STEP_TIME, 32'h0);
					write_reg(CFG_STEP_RATE, 32'h0);
				end
				3: begin
					write_reg(CFG_INT_LIMIT, 32'h7FFF_FFFF);
					write_reg(CFG_OUT_LIMIT, 32'h7FFF_FFFF);
					write_reg(CFG_STEP_TIME, 32'd1);
					write_reg(CFG_STEP_RATE, 32'd1);
				end
				default: ;
			endcase
			if (ph == RUN_PHASES - 1)
				idle_en = 1'b0;
			// Stall the receiver long enough to back up the input side
			if (ph == 0)
				hold_req = 1'b1;
			for (k = 0; k < PHASE_WORDS; k++)
				push_sample(random_sample());
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (err_count == 0 && drive_due_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
